// ===== hdl/mns_pkg.sv =====
// ----------------------------------------------------------------------------
// mns_pkg: melody note sequencer shared definitions
// Event codes, sequencer modes, result item layout, timing constants and the
// tone period table.
// ----------------------------------------------------------------------------
package mns_pkg;

  // event codes carried in the input item
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TIMER = 2'd1,
    OP_STOP  = 2'd2,
    OP_HALT  = 2'd3   // same handling as stop
  } mns_op_e;

  // song progress
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PLAY  = 2'd1,
    MODE_PAUSE = 2'd2
  } mns_mode_e;

  // one result item, first member in the highest bits
  typedef struct packed {
    logic        error;
    logic        finished;
    logic [7:0]  next_index;
    logic [15:0] timer_ticks;
    logic        timer_enable;
    logic [13:0] pwm_compare;
    logic [14:0] pwm_period;
    logic        pwm_enable;
  } mns_out_t;

  localparam int unsigned OutBits   = $bits(mns_out_t);
  localparam int unsigned OutBytes  = (OutBits + 7) / 8;
  localparam int unsigned OutPad    = OutBytes * 8 - OutBits;

  // configuration register indexes
  localparam logic RegTempo   = 1'b0;
  localparam logic RegSongLen = 1'b1;

  // beat time numerator (ticks per minute) and divider sizing
  localparam logic [19:0] BeatNumer = 20'd600000;
  localparam logic [7:0]  MinTempo  = 8'd10;
  // ceil(2^19 / 10): x * RestRecip >> 19 gives x / 10 for any 16-bit x
  localparam logic [15:0] RestRecip = 16'd52429;
  localparam logic [4:0]  DivSteps  = 5'd20;
  localparam logic [5:0]  FullNote  = 6'd16;

  // PWM period for each pitch
  function automatic logic [14:0] tone_period(input logic [5:0] idx);
    logic [14:0] p;
    case (idx)
      6'd0:  p = 15'd30581;  6'd1:  p = 15'd28860;  6'd2:  p = 15'd27248;
      6'd3:  p = 15'd25707;  6'd4:  p = 15'd24272;  6'd5:  p = 15'd22910;
      6'd6:  p = 15'd21622;  6'd7:  p = 15'd20408;  6'd8:  p = 15'd19259;
      6'd9:  p = 15'd18182;  6'd10: p = 15'd17160;  6'd11: p = 15'd16194;
      6'd12: p = 15'd15291;  6'd13: p = 15'd14430;  6'd14: p = 15'd13619;
      6'd15: p = 15'd12858;  6'd16: p = 15'd12136;  6'd17: p = 15'd11455;
      6'd18: p = 15'd10811;  6'd19: p = 15'd10204;  6'd20: p = 15'd9632;
      6'd21: p = 15'd9091;   6'd22: p = 15'd8580;   6'd23: p = 15'd8099;
      6'd24: p = 15'd7645;   6'd25: p = 15'd7215;   6'd26: p = 15'd6811;
      6'd27: p = 15'd6428;   6'd28: p = 15'd6067;   6'd29: p = 15'd5727;
      6'd30: p = 15'd5405;   6'd31: p = 15'd5102;   6'd32: p = 15'd4816;
      6'd33: p = 15'd4545;   6'd34: p = 15'd4290;   6'd35: p = 15'd4049;
      6'd36: p = 15'd3822;   6'd37: p = 15'd3608;   6'd38: p = 15'd3405;
      6'd39: p = 15'd3214;   6'd40: p = 15'd3034;   6'd41: p = 15'd2863;
      6'd42: p = 15'd2703;   6'd43: p = 15'd2551;   6'd44: p = 15'd2408;
      6'd45: p = 15'd2273;   6'd46: p = 15'd2145;
      default: p = 15'd2025;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/melody_note_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// melody_note_sequencer_top: buzzer melody sequencer
// Turns start, timer-expiry and stop items into PWM and duration timer
// settings, one result item per input item.
// ----------------------------------------------------------------------------
// Steps: a start item runs a 20-step pass of the restoring divider, a
//   reciprocal multiply for the rest time, a length scaling step and a result
//   step; a timer item while playing runs the scaling and result steps; other
//   items go to the result step, which loads the output reg once it is free.
// Throughput: one item at a time; ready again once the result is registered.
// Reset (async, active low): idle, index and timings zero, tempo 120, length 1.
module melody_note_sequencer_top #(
  parameter int TONE_COUNT = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] note_pitch, [11:6] note_length
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] pwm_enable, [15:1] pwm_period, [29:16] pwm_compare, [30] timer_enable,
  // [46:31] timer_ticks, [54:47] next_index, [55] finished, [56] error
  output logic [mns_pkg::OutBytes*8-1:0] m_axis_tdata
);
  import mns_pkg::*;

  localparam logic [5:0] LastTone = 6'(TONE_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REST,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e      state_q;
  logic [7:0]  tempo_q, song_len_q, size_q;
  mns_mode_e   mode_q;
  logic [7:0]  idx_q;
  logic [15:0] beat_q, rest_q;
  logic [1:0]  op_q;
  logic [5:0]  pitch_q, len_q;
  // divider
  logic [19:0] quo_q;
  logic [7:0]  rem_q, div_q;
  logic [4:0]  cnt_q;
  // scaled note time
  logic [15:0] t_q;
  logic        rest_note_q;
  // output register
  logic        out_vld_q;
  mns_out_t    out_q;

  logic        in_fire, out_free;
  logic [7:0]  tempo_eff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OutPad{1'b0}}, out_q};
  assign tempo_eff     = (tempo_q < MinTempo) ? MinTempo : tempo_q;

  // restoring divide step: one quotient bit per cycle
  logic [8:0]  div_shift;
  logic [9:0]  div_diff;
  logic        div_borrow;
  logic [7:0]  rem_nx;
  logic [19:0] quo_nx;

  always_comb begin
    div_shift  = {rem_q, quo_q[19]};
    div_diff   = {1'b0, div_shift} - {2'b00, div_q};
    div_borrow = div_diff[9];
    rem_nx     = div_borrow ? div_shift[7:0] : div_diff[7:0];
    quo_nx     = {quo_q[18:0], !div_borrow};
  end

  // rest time = beat / 10 by reciprocal multiply
  logic [31:0] rest_prod;

  assign rest_prod = 32'(beat_q) * 32'(RestRecip);

  // length scaling: beat * L / 4 for codes 1..16 (after taking off the rest mark)
  logic        rest_note;
  logic [5:0]  len_adj;
  logic        len_scale;
  logic [20:0] prod;

  always_comb begin
    rest_note = (len_q > FullNote);
    len_adj   = rest_note ? (len_q - FullNote) : len_q;
    len_scale = (len_adj != 6'd0) && (len_adj <= FullNote);
    prod      = 21'(beat_q) * 21'(len_adj[4:0]);
  end

  // result and next state for the current event
  mns_out_t    res;
  mns_mode_e   mode_fin;
  logic [7:0]  idx_fin;
  logic [5:0]  pitch_cl;
  logic [14:0] period;

  always_comb begin
    pitch_cl = (pitch_q > LastTone) ? LastTone : pitch_q;
    period   = tone_period(pitch_cl);
    res      = '0;
    mode_fin = mode_q;
    idx_fin  = idx_q;
    if (op_q != OP_START && op_q != OP_TIMER) begin
      mode_fin = MODE_IDLE;
    end else begin
      case (mode_q)
        MODE_PLAY: begin
          mode_fin         = MODE_PAUSE;
          res.pwm_enable   = !rest_note_q;
          res.pwm_period   = rest_note_q ? 15'd0 : period;
          res.pwm_compare  = rest_note_q ? 14'd0 : period[14:1];
          res.timer_enable = 1'b1;
          res.timer_ticks  = t_q - rest_q;
        end
        MODE_PAUSE: begin
          idx_fin          = idx_q + 8'd1;
          mode_fin         = (idx_fin >= size_q) ? MODE_IDLE : MODE_PLAY;
          res.timer_enable = 1'b1;
          res.timer_ticks  = rest_q;
        end
        default: begin
          res.error = 1'b1;
        end
      endcase
    end
    res.next_index = idx_fin;
    res.finished   = (mode_fin == MODE_IDLE);
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tempo_q     <= 8'd120;
      song_len_q  <= 8'd1;
      size_q      <= '0;
      mode_q      <= MODE_IDLE;
      idx_q       <= '0;
      beat_q      <= '0;
      rest_q      <= '0;
      op_q        <= '0;
      pitch_q     <= '0;
      len_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      cnt_q       <= '0;
      t_q         <= '0;
      rest_note_q <= 1'b0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSongLen) song_len_q <= cfg_data_i;
        else                         tempo_q    <= cfg_data_i;
      end
      if (state_q == ST_FIN && out_free) out_vld_q <= 1'b1;
      else if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q    <= s_axis_tuser;
            pitch_q <= s_axis_tdata[5:0];
            len_q   <= s_axis_tdata[11:6];
            case (s_axis_tuser)
              OP_START: begin
                quo_q   <= BeatNumer;
                rem_q   <= '0;
                div_q   <= tempo_eff;
                cnt_q   <= '0;
                state_q <= ST_DIV;
              end
              OP_TIMER: state_q <= (mode_q == MODE_PLAY) ? ST_MUL : ST_FIN;
              default:  state_q <= ST_FIN;
            endcase
          end
        end
        ST_DIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == DivSteps - 5'd1) begin
            // beat time done, rest time next
            beat_q  <= quo_nx[15:0];
            state_q <= ST_REST;
          end
        end
        ST_REST: begin
          rest_q  <= {3'b000, rest_prod[31:19]};
          size_q  <= song_len_q;
          mode_q  <= MODE_PLAY;
          idx_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          t_q         <= len_scale ? prod[17:2] : beat_q;
          rest_note_q <= rest_note;
          state_q     <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_q     <= res;
            mode_q    <= mode_fin;
            idx_q     <= idx_fin;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // an error result always reports the block idle
  a_err_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.error |-> out_q.finished)
    else $error("error result without finished");

  // a sounding tone always comes with a loaded timer
  a_pwm_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.pwm_enable |-> out_q.timer_enable && !out_q.error)
    else $error("tone without timer load");

  // an accepted item leaves the block not ready in the following cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("ready right after accept");

  // divider step count stays within one pass
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < DivSteps)
    else $error("divider step count overrun");

endmodule
